// ----- rtl/core/crr_pkg.sv -----
package crr_pkg;

    localparam int MAX_STAGES  = 8;
    localparam int ENTRIES     = 32;
    localparam int VALUE_BITS  = 40;
    localparam int OUT_BITS    = VALUE_BITS + 1;
    localparam int STAGE_W     = $clog2(MAX_STAGES);
    localparam int SLOT_W      = $clog2(ENTRIES);
    localparam int CNT_W       = 4;
    localparam int OP_W        = 2;

    localparam logic [CNT_W-1:0] STAGES_RESET = 4'd7;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_XLATE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // stored form of a range entry: source start, exclusive end, dest - source
    typedef struct packed {
        logic [VALUE_BITS-1:0] src;
        logic [OUT_BITS-1:0]   lim;
        logic [OUT_BITS-1:0]   delta;
    } t_entry;

    typedef t_entry [ENTRIES-1:0] t_row;

    typedef struct packed {
        logic               en;
        logic [STAGE_W-1:0] stage;
        logic [SLOT_W-1:0]  slot;
        t_entry             entry;
    } t_wr;

    function automatic t_entry make_entry(
        input logic [VALUE_BITS-1:0] dest,
        input logic [VALUE_BITS-1:0] src,
        input logic [VALUE_BITS-1:0] len
    );
        t_entry e;
        e.src   = src;
        e.lim   = {1'b0, src} + {1'b0, len};
        e.delta = {1'b0, dest} - {1'b0, src};
        return e;
    endfunction

endpackage

// ----- rtl/core/crr_table.sv -----
module crr_table import crr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_wr                i_wr,
    input  logic [STAGE_W-1:0] i_rd_addr,
    output t_row               o_row,
    output logic [ENTRIES-1:0] o_vld
);

    t_row               r_mem [MAX_STAGES];
    logic [ENTRIES-1:0] r_vld [MAX_STAGES];
    t_row               r_row;
    logic [ENTRIES-1:0] r_row_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.stage][i_wr.slot] <= i_wr.entry;
        end
        r_row <= r_mem[i_rd_addr];
    end

    // entries never loaded since reset read as disabled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_STAGES; s++) begin
                r_vld[s] <= '0;
            end
            r_row_vld <= '0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.stage][i_wr.slot] <= 1'b1;
            end
            r_row_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_row = r_row;
    assign o_vld = r_row_vld;

endmodule

// ----- rtl/core/crr_match.sv -----
module crr_match import crr_pkg::*; (
    input  logic [OUT_BITS-1:0] i_value,
    input  t_row                i_row,
    input  logic [ENTRIES-1:0]  i_vld,
    output logic [OUT_BITS-1:0] o_value
);

    logic [ENTRIES-1:0]  hit;
    logic [ENTRIES-1:0]  first;
    logic [OUT_BITS-1:0] delta_sel;

    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            hit[k] = i_vld[k]
                   && (i_value >= {1'b0, i_row[k].src})
                   && (i_value < i_row[k].lim);
        end
    end

    // lowest-index hit wins
    assign first = hit & (~hit + ENTRIES'(1));

    always_comb begin
        delta_sel = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            delta_sel = delta_sel | (first[k] ? i_row[k].delta : '0);
        end
    end

    assign o_value = (|hit) ? (i_value + delta_sel) : i_value;

endmodule

// ----- rtl/core/cascaded_range_remap_core.sv -----
// a translate item walks the table stages in turn, n being the stage count (saturated at 8);
// other items go straight to the result register; a new item is taken only once the last
// result is registered, so items do not overlap; the range matcher handles one stage per
// cycle and is reused for each stage in turn
// reset: synchronous active-low, clears entry valid bits, the minimum and control;
// stage count returns to 7
module cascaded_range_remap_core import crr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [2:0]            i_stage_select,
    input  logic [4:0]            i_entry_slot,
    input  logic [VALUE_BITS-1:0] i_dest_base,
    input  logic [VALUE_BITS-1:0] i_source_base,
    input  logic [VALUE_BITS-1:0] i_span_length,
    input  logic [VALUE_BITS-1:0] i_query_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_BITS-1:0]   o_mapped_value,
    output logic [OUT_BITS-1:0]   o_least_seen,
    output logic                  o_least_valid,
    input  logic                  i_cfg_wr_en,
    input  logic [CNT_W-1:0]      i_cfg_wr_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_POST = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_stage, n_stage;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [OP_W-1:0]     r_op, n_op;
    logic [OUT_BITS-1:0] r_val, n_val;
    logic [OUT_BITS-1:0] r_min, n_min;
    logic                r_min_vld, n_min_vld;
    logic [CNT_W-1:0]    r_stages;
    logic                r_out_valid, n_out_valid;
    logic [OUT_BITS-1:0] r_out_mapped, n_out_mapped;
    logic [OUT_BITS-1:0] r_out_least, n_out_least;
    logic                r_out_lvld, n_out_lvld;

    logic                acc;
    logic [CNT_W-1:0]    stage_lim;
    logic [CNT_W-1:0]    stage_next;
    logic [STAGE_W-1:0]  rd_addr;
    t_wr                 wr;
    t_row                row;
    logic [ENTRIES-1:0]  row_vld;
    logic [OUT_BITS-1:0] match_val;

    assign o_ready    = (r_state == S_IDLE);
    assign acc        = i_valid && o_ready;
    assign stage_lim  = (r_stages > CNT_W'(MAX_STAGES)) ? CNT_W'(MAX_STAGES) : r_stages;
    assign stage_next = r_stage + CNT_W'(1);

    always_comb begin
        wr.en    = acc && (i_opcode == OP_LOAD);
        wr.stage = i_stage_select;
        wr.slot  = i_entry_slot;
        wr.entry = make_entry(i_dest_base, i_source_base, i_span_length);
    end

    crr_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_row     (row),
        .o_vld     (row_vld)
    );

    crr_match u_match (
        .i_value (r_val),
        .i_row   (row),
        .i_vld   (row_vld),
        .o_value (match_val)
    );

    always_comb begin
        n_state      = r_state;
        n_stage      = r_stage;
        n_n          = r_n;
        n_op         = r_op;
        n_val        = r_val;
        n_min        = r_min;
        n_min_vld    = r_min_vld;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_mapped = r_out_mapped;
        n_out_least  = r_out_least;
        n_out_lvld   = r_out_lvld;
        rd_addr      = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_op    = i_opcode;
                    n_val   = {1'b0, i_query_value};
                    n_stage = '0;
                    n_n     = stage_lim;
                    if ((i_opcode == OP_XLATE) && (stage_lim != '0)) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_POST;
                    end
                end
            end
            S_RUN: begin
                // row for r_stage is in the read register; fetch the next one
                n_val   = match_val;
                n_stage = stage_next;
                rd_addr = stage_next[STAGE_W-1:0];
                if (stage_next == r_n) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_mapped = '0;
                    n_state      = S_IDLE;
                    case (r_op)
                        OP_XLATE: begin
                            if (!r_min_vld || (r_val < r_min)) begin
                                n_min     = r_val;
                                n_min_vld = 1'b1;
                            end
                            n_out_mapped = r_val;
                        end
                        OP_CLEAR: begin
                            n_min     = '0;
                            n_min_vld = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                    n_out_least = n_min;
                    n_out_lvld  = n_min_vld;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= '0;
            r_n         <= '0;
            r_op        <= OP_LOAD;
            r_min       <= '0;
            r_min_vld   <= 1'b0;
            r_stages    <= STAGES_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_n         <= n_n;
            r_op        <= n_op;
            r_min       <= n_min;
            r_min_vld   <= n_min_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_stages <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_out_mapped <= n_out_mapped;
        r_out_least  <= n_out_least;
        r_out_lvld   <= n_out_lvld;
    end

    assign o_valid        = r_out_valid;
    assign o_mapped_value = r_out_mapped;
    assign o_least_seen   = r_out_least;
    assign o_least_valid  = r_out_lvld;

`ifndef SYNTHESIS
    a_stage_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_stage < r_n))
        else $error("stage counter ran past the stage count");

    a_run_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_opcode == OP_XLATE) && (stage_lim != '0)) |=> (r_state == S_RUN))
        else $error("translate item did not start the stage walk");

    a_min_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_least_valid) |-> (o_least_seen == '0))
        else $error("minimum shown without any translated item");

    a_min_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_min_vld) && r_min_vld) |-> (r_min <= $past(r_min)))
        else $error("running minimum increased");
`endif

endmodule

// ----- tb/crr_remap_checker.sv -----
module crr_remap_checker import crr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [STAGE_W-1:0]    i_stage_select,
    input  logic [SLOT_W-1:0]     i_entry_slot,
    input  logic [VALUE_BITS-1:0] i_dest_base,
    input  logic [VALUE_BITS-1:0] i_source_base,
    input  logic [VALUE_BITS-1:0] i_span_length,
    input  logic [VALUE_BITS-1:0] i_query_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_BITS-1:0]   i_mapped_value,
    input  logic [OUT_BITS-1:0]   i_least_seen,
    input  logic                  i_least_valid,
    input  logic                  i_cfg_wr_en,
    input  logic [CNT_W-1:0]      i_cfg_wr_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    typedef struct packed {
        logic [OUT_BITS-1:0] mapped;
        logic [OUT_BITS-1:0] least;
        logic                least_ok;
    } t_remap_result;

    logic [VALUE_BITS-1:0] tbl_dest [MAX_STAGES][ENTRIES];
    logic [VALUE_BITS-1:0] tbl_src  [MAX_STAGES][ENTRIES];
    logic [VALUE_BITS-1:0] tbl_len  [MAX_STAGES][ENTRIES];
    logic [OUT_BITS-1:0]   min_value;
    logic                  min_valid;
    logic [CNT_W-1:0]      stage_count;

    t_remap_result due_results[$];
    int            mismatch_count = 0;
    int            due_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = due_count;

    function automatic logic [OUT_BITS-1:0] translate_value(input logic [VALUE_BITS-1:0] q);
        logic [OUT_BITS-1:0] v;
        logic [OUT_BITS-1:0] lo;
        logic [OUT_BITS-1:0] hi;
        int                  depth;
        logic                hit;
        v = {1'b0, q};
        depth = (stage_count > MAX_STAGES) ? MAX_STAGES : int'(stage_count);
        for (int s = 0; s < depth; s++) begin
            hit = 1'b0;
            // lowest slot that holds the value wins
            for (int k = 0; k < ENTRIES; k++) begin
                lo = {1'b0, tbl_src[s][k]};
                hi = lo + {1'b0, tbl_len[s][k]};
                if (!hit && tbl_len[s][k] != '0 && v >= lo && v < hi) begin
                    v = {1'b0, tbl_dest[s][k]} + (v - lo);
                    hit = 1'b1;
                end
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_remap_result got;
        t_remap_result want;
        logic [OUT_BITS-1:0] v;
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_STAGES; s++) begin
                for (int k = 0; k < ENTRIES; k++) begin
                    tbl_dest[s][k] = '0;
                    tbl_src[s][k]  = '0;
                    tbl_len[s][k]  = '0;
                end
            end
            min_value   = '0;
            min_valid   = 1'b0;
            stage_count = STAGES_RESET;
            due_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                stage_count = i_cfg_wr_data;
            end
            if (i_out_valid && i_out_ready) begin
                got.mapped   = i_mapped_value;
                got.least    = i_least_seen;
                got.least_ok = i_least_valid;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected item: expected none, %s %h least %h valid %b",
                             $time, "actual mapped", got.mapped, got.least, got.least_ok);
                    mismatch_count++;
                end else begin
                    want = due_results.pop_front();
                    if (got.mapped !== want.mapped) begin
                        $display("%0t: mapped_value expected %h actual %h",
                                 $time, want.mapped, got.mapped);
                        mismatch_count++;
                    end
                    if (got.least !== want.least) begin
                        $display("%0t: least_seen expected %h actual %h",
                                 $time, want.least, got.least);
                        mismatch_count++;
                    end
                    if (got.least_ok !== want.least_ok) begin
                        $display("%0t: least_valid expected %b actual %b",
                                 $time, want.least_ok, got.least_ok);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                v = '0;
                case (i_opcode)
                    OP_LOAD: begin
                        tbl_dest[i_stage_select][i_entry_slot] = i_dest_base;
                        tbl_src[i_stage_select][i_entry_slot]  = i_source_base;
                        tbl_len[i_stage_select][i_entry_slot]  = i_span_length;
                    end
                    OP_XLATE: begin
                        v = translate_value(i_query_value);
                        if (!min_valid || v < min_value) begin
                            min_value = v;
                            min_valid = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        min_value = '0;
                        min_valid = 1'b0;
                    end
                    default: ;
                endcase
                want.mapped   = v;
                want.least    = min_value;
                want.least_ok = min_valid;
                due_results.push_back(want);
            end
        end
        due_count = due_results.size();
    end

endmodule

// ----- tb/tb_cascaded_range_remap_core.sv -----
module tb_cascaded_range_remap_core;
    import crr_pkg::*;

    localparam logic [OP_W-1:0]       OP_SPARE = 2'd3;
    localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [OP_W-1:0]       i_opcode;
    logic [2:0]            i_stage_select;
    logic [4:0]            i_entry_slot;
    logic [VALUE_BITS-1:0] i_dest_base;
    logic [VALUE_BITS-1:0] i_source_base;
    logic [VALUE_BITS-1:0] i_span_length;
    logic [VALUE_BITS-1:0] i_query_value;
    logic                  o_valid;
    logic                  i_ready;
    logic [OUT_BITS-1:0]   o_mapped_value;
    logic [OUT_BITS-1:0]   o_least_seen;
    logic                  o_least_valid;
    logic                  i_cfg_wr_en;
    logic [CNT_W-1:0]      i_cfg_wr_data;

    int                    mismatches;
    int                    pending;
    bit                    quiet = 1'b0;
    logic [VALUE_BITS-1:0] anchors [16];

    cascaded_range_remap_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_stage_select (i_stage_select),
        .i_entry_slot   (i_entry_slot),
        .i_dest_base    (i_dest_base),
        .i_source_base  (i_source_base),
        .i_span_length  (i_span_length),
        .i_query_value  (i_query_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_mapped_value (o_mapped_value),
        .o_least_seen   (o_least_seen),
        .o_least_valid  (o_least_valid),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    crr_remap_checker remap_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_opcode       (i_opcode),
        .i_stage_select (i_stage_select),
        .i_entry_slot   (i_entry_slot),
        .i_dest_base    (i_dest_base),
        .i_source_base  (i_source_base),
        .i_span_length  (i_span_length),
        .i_query_value  (i_query_value),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_mapped_value (o_mapped_value),
        .i_least_seen   (o_least_seen),
        .i_least_valid  (o_least_valid),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("cascaded_range_remap_core: mismatch");
        $finish;
    end

    // result side back-pressure
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = quiet || ($urandom_range(0, 99) >= 16);
        end
    end

    function automatic logic [VALUE_BITS-1:0] rand_value();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[VALUE_BITS-1:0];
    endfunction

    // bases mostly from a shared pool so ranges chain from stage to stage
    function automatic logic [VALUE_BITS-1:0] pick_base();
        if ($urandom_range(0, 99) < 80) begin
            return anchors[$urandom_range(0, 15)];
        end
        return rand_value();
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end
        if (r < 65) begin
            return VALUE_BITS'($urandom_range(1, 64));
        end
        if (r < 90) begin
            return VALUE_BITS'($urandom_range(1, 1 << 20));
        end
        return rand_value();
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [2:0] st,
                             input logic [4:0] slot, input logic [VALUE_BITS-1:0] d,
                             input logic [VALUE_BITS-1:0] s, input logic [VALUE_BITS-1:0] l,
                             input logic [VALUE_BITS-1:0] q);
        while (!quiet && $urandom_range(0, 99) < 16) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_opcode       = op;
        i_stage_select = st;
        i_entry_slot   = slot;
        i_dest_base    = d;
        i_source_base  = s;
        i_span_length  = l;
        i_query_value  = q;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_stage_count(input logic [CNT_W-1:0] n);
        drain_results();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = n;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    task automatic send_random_item();
        logic [OP_W-1:0]       op;
        logic [VALUE_BITS-1:0] q;
        int                    r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            op = OP_LOAD;
        end else if (r < 85) begin
            op = OP_XLATE;
        end else if (r < 93) begin
            op = OP_CLEAR;
        end else begin
            op = OP_SPARE;
        end
        if ($urandom_range(0, 3) != 0) begin
            q = anchors[$urandom_range(0, 15)] + VALUE_BITS'($urandom_range(0, 80));
        end else begin
            q = rand_value();
        end
        send_item(op, 3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                  pick_base(), pick_base(), pick_span(), q);
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] schedule [6];
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_opcode       = OP_LOAD;
        i_stage_select = '0;
        i_entry_slot   = '0;
        i_dest_base    = '0;
        i_source_base  = '0;
        i_span_length  = '0;
        i_query_value  = '0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = STAGES_RESET;
        anchors[0] = '0;
        anchors[1] = ALL_ONES - 40'd4095;
        for (int i = 2; i < 16; i++) begin
            anchors[i] = rand_value();
        end
        schedule[0] = 4'd8;
        schedule[1] = 4'd0;
        schedule[2] = 4'd1;
        schedule[3] = 4'd15;
        schedule[4] = CNT_W'($urandom_range(0, 15));
        schedule[5] = STAGES_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table: values pass through, minimum tracking and clear
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, '0);
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, ALL_ONES);
        send_item(OP_CLEAR, 3'd0, 5'd0, '0, '0, '0, '0);
        send_item(OP_SPARE, 3'd7, 5'd31, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, 40'h12345);
        // overlapping ranges in stage 0, lower slot wins
        send_item(OP_LOAD, 3'd0, 5'd5, 40'h5000, 40'h100, 40'h10, '0);
        send_item(OP_LOAD, 3'd0, 5'd2, 40'h9000, 40'h108, 40'h4, '0);
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, 40'h109);
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, 40'h10f);
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, 40'h110);
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, 40'h100);
        // zero span disables the entry
        send_item(OP_LOAD, 3'd0, 5'd2, 40'h9000, 40'h108, '0, '0);
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, 40'h109);
        // chain into stage 1
        send_item(OP_LOAD, 3'd1, 5'd0, '0, 40'h5000, 40'h100, '0);
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, 40'h109);
        // full-width entries, the sum grows into the extra output bit
        send_item(OP_LOAD, 3'd7, 5'd31, ALL_ONES, '0, ALL_ONES, '0);
        send_item(OP_LOAD, 3'd2, 5'd31, ALL_ONES, '0, ALL_ONES, '0);
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, ALL_ONES - 40'd1);
        send_item(OP_XLATE, 3'd0, 5'd0, '0, '0, '0, ALL_ONES);
        send_item(OP_CLEAR, 3'd0, 5'd0, '0, '0, '0, '0);
        send_item(OP_CLEAR, 3'd0, 5'd0, '0, '0, '0, '0);

        for (int p = 0; p < 6; p++) begin
            set_stage_count(schedule[p]);
            quiet = (p == 3);
            repeat (150) begin
                if ($urandom_range(0, 99) == 0) begin
                    drain_results();
                end
                send_random_item();
            end
            quiet = 1'b0;
        end

        drain_results();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("cascaded_range_remap_core: match");
        end else begin
            $display("cascaded_range_remap_core: mismatch");
        end
        $finish;
    end

endmodule
